// ===== sv/sirc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the sinc rate converter.
// No dependencies; every other file but sirc_ram refers to it by scoped names.
package sirc_pkg;

    localparam int RING_DEPTH  = 128;
    localparam int RING_AW     = 7;
    localparam int FILTER_TAPS = 65;
    localparam int COEF_AW     = 7;
    localparam int HALF_WINDOW = 25;
    localparam int WIN_TAPS    = 2 * HALF_WINDOW;
    localparam int PHASE_STEPS = 256;
    localparam int PHASE_BITS  = 8;
    localparam int ROM_DEPTH   = WIN_TAPS * PHASE_STEPS;
    localparam int ROM_AW      = 14;
    localparam int MAX_OUT     = 8;
    localparam int W_BITS      = 19;
    localparam int ACC_W       = 48;
    localparam logic [19:0] UNITY_STEP = 20'd65536;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIR_IN,
        ST_FIR_IN_DRAIN,
        ST_SRC_WR,
        ST_CHECK,
        ST_INTERP,
        ST_INTERP_DRAIN,
        ST_OUT_WR,
        ST_FIR_OUT,
        ST_FIR_OUT_DRAIN,
        ST_EMIT
    } st_t;

    // operand source of the shared multiplier
    typedef enum logic [1:0] {
        SEL_RAW,
        SEL_INTERP,
        SEL_OUT
    } mac_sel_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

    // saturate to 18 bits
    function automatic logic signed [17:0] clamp18(input logic signed [31:0] v);
        logic signed [17:0] r;
        if (v > 32'sd131071) begin
            r = 18'sd131071;
        end else if (v < -32'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // saturate to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sd32767;
        end else if (v < -48'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // restoring division, used only while building the sinc table
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi*v/PHASE_STEPS) in Q30 on the quarter wave
    function automatic logic [63:0] quarter_sine(input int v);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (PI_Q30 * 64'(v)) >> PHASE_BITS;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    // sinc weight for distance k + p/PHASE_STEPS, Q2.17
    function automatic logic signed [W_BITS-1:0] sinc_weight(input int k, input int p);
        int          m;
        int          v;
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] w;
        logic        neg;
        m = k * PHASE_STEPS + p;
        if (m == 0) begin
            return W_BITS'(1 << 17);
        end
        v   = (p <= PHASE_STEPS - p) ? p : PHASE_STEPS - p;
        mag = (m < 0) ? 64'(-m) : 64'(m);
        num = (quarter_sine(v) * 64'(PHASE_STEPS)) << 17;
        den = PI_Q30 * mag;
        w   = div64(num + (den >> 1), den);
        neg = ((k & 1) != 0) != (m < 0);
        return neg ? -W_BITS'(w) : W_BITS'(w);
    endfunction

endpackage

// ===== sv/sirc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sirc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sirc_sinc_rom.sv =====
`timescale 1ns / 1ps
// Sinc weight ROM, one row of PHASE_STEPS phases per window tap.
// Depends on sirc_pkg for the table builder and sizes.
module sirc_sinc_rom (
    input  logic                                  aclk,
    input  logic [sirc_pkg::ROM_AW-1:0]           addr,
    output logic signed [sirc_pkg::W_BITS-1:0]    weight
);

    logic signed [sirc_pkg::W_BITS-1:0] rom_tbl [sirc_pkg::ROM_DEPTH];
    logic signed [sirc_pkg::W_BITS-1:0] weight_reg;

    // build the table at elaboration: tap j stands at distance HALF_WINDOW - j
    for (genvar j = 0; j < sirc_pkg::WIN_TAPS; j++) begin : g_tap
        for (genvar p = 0; p < sirc_pkg::PHASE_STEPS; p++) begin : g_ph
            localparam logic signed [sirc_pkg::W_BITS-1:0] W =
                sirc_pkg::sinc_weight(sirc_pkg::HALF_WINDOW - j, p);
            assign rom_tbl[j * sirc_pkg::PHASE_STEPS + p] = W;
        end
    end

    // registered lookup
    always_ff @(posedge aclk) begin
        weight_reg <= rom_tbl[addr];
    end

    assign weight = weight_reg;

endmodule

// ===== sv/sirc_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with rounding of the sum by 2^17.
// Depends on sirc_pkg for the control struct and widths.
module sirc_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sirc_pkg::mac_ctrl_t               ctrl,
    input  logic signed [17:0]                a,
    input  logic signed [sirc_pkg::W_BITS-1:0] b,
    output logic signed [31:0]                rnd,
    output logic                              busy
);

    logic signed [36:0]               prod_reg;
    logic                             acc_en_reg;
    logic signed [sirc_pkg::ACC_W-1:0] acc_reg;
    logic [sirc_pkg::ACC_W-1:0]       mag;
    logic [sirc_pkg::ACC_W-1:0]       mag_rnd;

    // product stage valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg <= 1'b0;
        end else begin
            acc_en_reg <= ctrl.mul_en;
        end
    end

    // register the product, then accumulate it
    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= a * b;
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (acc_en_reg) begin
            acc_reg <= acc_reg + sirc_pkg::ACC_W'(prod_reg);
        end
    end

    // round half away from zero on the magnitude
    always_comb begin
        mag     = acc_reg[sirc_pkg::ACC_W-1] ? sirc_pkg::ACC_W'(-acc_reg)
                                             : sirc_pkg::ACC_W'(acc_reg);
        mag_rnd = (mag + sirc_pkg::ACC_W'(1 << 16)) >> 17;
        rnd     = acc_reg[sirc_pkg::ACC_W-1] ? -$signed(mag_rnd[31:0])
                                             : $signed(mag_rnd[31:0]);
    end

    assign busy = ctrl.mul_en | acc_en_reg;

endmodule

// ===== sv/sinc_interp_rate_converter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the windowed-sinc sample rate converter.
// Depends on sirc_pkg, sirc_ram, sirc_sinc_rom and sirc_mac.
//
// Usage:
//   s_* carries one request per item: s_tuser[0] is the opcode (0 = audio
//   sample, 1 = coefficient write), s_tdata holds sample_in, coef_index and
//   coef_value. m_* returns resampled samples; m_tlast marks the final
//   result caused by one audio request. cfg_* writes ratio_step (Q4.16).
//   An audio sample runs the 65-tap input FIR (only when downsampling),
//   then per result the 50-tap sinc sum and, when upsampling, the 65-tap
//   output FIR, for up to eight results. All of this work goes through
//   the single shared multiplier, fed one tap a cycle from the ring RAMs,
//   the coefficient RAM and the sinc ROM.
//   s_tready is high only while the sequencer is idle; a result waits in
//   the output register while the next request is taken. When the
//   receiver stalls, the sequencer holds before loading the next result.
//   Reset (aresetn low, synchronous) clears the pointers and the phase and
//   sets ratio_step to unity; then a clearing pass over all 128 slots zeroes the
//   three rings with s_tready low. Coefficients must be written before use.
module sinc_interp_rate_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_in[15:0], coef_index[22:16], coef_value[40:23]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out[15:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);

    localparam int AW = sirc_pkg::RING_AW;

    sirc_pkg::st_t      state_reg, state_next;
    logic [6:0]         n_reg, n_next;
    logic [AW-1:0]      in_ptr_reg, in_ptr_next;
    logic [AW-1:0]      out_ptr_reg, out_ptr_next;
    logic [22:0]        phase_reg, phase_next;
    logic [3:0]         count_reg, count_next;
    logic [19:0]        ratio_reg;
    logic signed [15:0] sample_reg;
    logic signed [17:0] y_reg, y_next;
    logic signed [31:0] val_reg, val_next;
    logic               mvalid_reg, mvalid_next;
    logic [15:0]        mdata_reg, mdata_next;
    logic               mlast_reg, mlast_next;

    logic               s_acc;
    logic               s_audio;
    logic               clearing;
    logic               issue;
    sirc_pkg::mac_sel_t sel;
    logic               issue_d1_reg;
    sirc_pkg::mac_sel_t sel_d1_reg;
    sirc_pkg::mac_ctrl_t mac_ctrl;
    logic               mac_clear;
    logic signed [31:0] mac_rnd;
    logic               mac_busy;
    logic signed [17:0] op_a;
    logic signed [sirc_pkg::W_BITS-1:0] op_b;

    logic               raw_we, coef_we, src_we, out_we;
    logic [AW-1:0]      raw_raddr, src_raddr, out_raddr;
    logic [sirc_pkg::COEF_AW-1:0] coef_raddr;
    logic [15:0]        raw_rdata, raw_wdata;
    logic [17:0]        coef_rdata, src_rdata, out_rdata, src_wdata, out_wdata;
    logic signed [sirc_pkg::W_BITS-1:0] rom_rdata;
    logic [sirc_pkg::ROM_AW-1:0] rom_addr;

    logic [AW-1:0]      target;
    logic [22:0]        phase_adv;
    logic               emit_go;
    logic signed [47:0] val_w;
    logic signed [47:0] scaled;
    logic               down_mode, up_mode;

    assign s_acc     = s_tvalid & s_tready;
    assign s_audio   = s_acc && !s_tuser[0];
    assign clearing  = state_reg == sirc_pkg::ST_CLEAR;
    assign cfg_ready = 1'b1;
    assign down_mode = ratio_reg > sirc_pkg::UNITY_STEP;
    assign up_mode   = ratio_reg < sirc_pkg::UNITY_STEP;
    assign target    = in_ptr_reg - AW'(sirc_pkg::HALF_WINDOW);
    assign phase_adv = phase_reg + {3'b000, ratio_reg};
    assign emit_go   = !mvalid_reg || m_tready;

    // ring, coefficient and sinc memories; the clearing pass zeroes the rings
    assign raw_we     = s_audio || clearing;
    assign raw_wdata  = clearing ? 16'd0 : s_tdata[15:0];
    assign coef_we    = s_acc && s_tuser[0]
                        && (s_tdata[22:16] < 7'(sirc_pkg::FILTER_TAPS));
    assign raw_raddr  = in_ptr_reg - n_reg[AW-1:0];
    assign coef_raddr = n_reg;
    assign src_raddr  = phase_reg[22:16] - AW'(sirc_pkg::HALF_WINDOW) + n_reg[AW-1:0];
    assign out_raddr  = out_ptr_reg - n_reg[AW-1:0];
    assign rom_addr   = {n_reg[5:0], phase_reg[15:16-sirc_pkg::PHASE_BITS]};
    assign src_we     = (state_reg == sirc_pkg::ST_SRC_WR) || clearing;
    assign src_wdata  = clearing  ? 18'd0
                      : down_mode ? sirc_pkg::clamp18(mac_rnd) : 18'(sample_reg);
    assign out_we     = (state_reg == sirc_pkg::ST_OUT_WR) || clearing;
    assign out_wdata  = clearing ? 18'd0 : y_reg;

    sirc_ram #(.WIDTH(16), .DEPTH(sirc_pkg::RING_DEPTH)) u_raw (
        .aclk(aclk), .we(raw_we), .waddr(in_ptr_reg), .wdata(raw_wdata),
        .raddr(raw_raddr), .rdata(raw_rdata)
    );

    sirc_ram #(.WIDTH(18), .DEPTH(sirc_pkg::FILTER_TAPS)) u_coef (
        .aclk(aclk), .we(coef_we), .waddr(s_tdata[22:16]), .wdata(s_tdata[40:23]),
        .raddr(coef_raddr), .rdata(coef_rdata)
    );

    sirc_ram #(.WIDTH(18), .DEPTH(sirc_pkg::RING_DEPTH)) u_src (
        .aclk(aclk), .we(src_we), .waddr(in_ptr_reg), .wdata(src_wdata),
        .raddr(src_raddr), .rdata(src_rdata)
    );

    sirc_ram #(.WIDTH(18), .DEPTH(sirc_pkg::RING_DEPTH)) u_out (
        .aclk(aclk), .we(out_we), .waddr(out_ptr_reg), .wdata(out_wdata),
        .raddr(out_raddr), .rdata(out_rdata)
    );

    sirc_sinc_rom u_rom (
        .aclk(aclk), .addr(rom_addr), .weight(rom_rdata)
    );

    // align select with the registered read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_d1_reg <= 1'b0;
        end else begin
            issue_d1_reg <= issue;
        end
        sel_d1_reg <= sel;
    end

    // pick multiplier operands
    always_comb begin
        unique case (sel_d1_reg)
            sirc_pkg::SEL_RAW:    op_a = 18'($signed(raw_rdata));
            sirc_pkg::SEL_INTERP: op_a = $signed(src_rdata);
            sirc_pkg::SEL_OUT:    op_a = $signed(out_rdata);
            default:              op_a = '0;
        endcase
        op_b = (sel_d1_reg == sirc_pkg::SEL_INTERP) ? rom_rdata
                                                    : sirc_pkg::W_BITS'($signed(coef_rdata));
    end

    assign mac_ctrl.clear  = mac_clear;
    assign mac_ctrl.mul_en = issue_d1_reg;

    sirc_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .ctrl(mac_ctrl),
        .a(op_a), .b(op_b), .rnd(mac_rnd), .busy(mac_busy)
    );

    // scale by 32767/32768 toward zero
    always_comb begin
        val_w  = 48'(val_reg);
        scaled = (val_w <<< 15) - val_w;
        if (scaled < 0) begin
            scaled = scaled + 48'sd32767;
        end
        scaled = scaled >>> 15;
    end

    // sequencer: next state and datapath control
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        in_ptr_next  = in_ptr_reg;
        out_ptr_next = out_ptr_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        y_next       = y_reg;
        val_next     = val_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        mlast_next   = mlast_reg;
        s_tready     = 1'b0;
        issue        = 1'b0;
        sel          = sirc_pkg::SEL_RAW;
        mac_clear    = 1'b0;
        unique case (state_reg)
            sirc_pkg::ST_CLEAR: begin
                // walk every ring slot once; both pointers wrap back to zero
                in_ptr_next  = in_ptr_reg + 7'd1;
                out_ptr_next = out_ptr_reg + 7'd1;
                if (in_ptr_reg == AW'(sirc_pkg::RING_DEPTH - 1)) begin
                    state_next = sirc_pkg::ST_IDLE;
                end
            end
            sirc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_audio) begin
                    n_next    = '0;
                    mac_clear = 1'b1;
                    state_next = down_mode ? sirc_pkg::ST_FIR_IN : sirc_pkg::ST_SRC_WR;
                end
            end
            sirc_pkg::ST_FIR_IN: begin
                issue  = 1'b1;
                sel    = sirc_pkg::SEL_RAW;
                n_next = n_reg + 7'd1;
                if (n_reg == 7'(sirc_pkg::FILTER_TAPS - 1)) begin
                    state_next = sirc_pkg::ST_FIR_IN_DRAIN;
                end
            end
            sirc_pkg::ST_FIR_IN_DRAIN: begin
                if (!mac_busy) begin
                    state_next = sirc_pkg::ST_SRC_WR;
                end
            end
            sirc_pkg::ST_SRC_WR: begin
                count_next = '0;
                state_next = sirc_pkg::ST_CHECK;
            end
            sirc_pkg::ST_CHECK: begin
                if (count_reg < 4'(sirc_pkg::MAX_OUT) && phase_reg[22:16] == target) begin
                    n_next     = '0;
                    mac_clear  = 1'b1;
                    state_next = sirc_pkg::ST_INTERP;
                end else begin
                    in_ptr_next = in_ptr_reg + 7'd1;
                    state_next  = sirc_pkg::ST_IDLE;
                end
            end
            sirc_pkg::ST_INTERP: begin
                issue  = 1'b1;
                sel    = sirc_pkg::SEL_INTERP;
                n_next = n_reg + 7'd1;
                if (n_reg == 7'(sirc_pkg::WIN_TAPS - 1)) begin
                    state_next = sirc_pkg::ST_INTERP_DRAIN;
                end
            end
            sirc_pkg::ST_INTERP_DRAIN: begin
                if (!mac_busy) begin
                    y_next     = sirc_pkg::clamp18(mac_rnd);
                    state_next = sirc_pkg::ST_OUT_WR;
                end
            end
            sirc_pkg::ST_OUT_WR: begin
                val_next = 32'(y_reg);
                if (up_mode) begin
                    n_next     = '0;
                    mac_clear  = 1'b1;
                    state_next = sirc_pkg::ST_FIR_OUT;
                end else begin
                    state_next = sirc_pkg::ST_EMIT;
                end
            end
            sirc_pkg::ST_FIR_OUT: begin
                issue  = 1'b1;
                sel    = sirc_pkg::SEL_OUT;
                n_next = n_reg + 7'd1;
                if (n_reg == 7'(sirc_pkg::FILTER_TAPS - 1)) begin
                    state_next = sirc_pkg::ST_FIR_OUT_DRAIN;
                end
            end
            sirc_pkg::ST_FIR_OUT_DRAIN: begin
                if (!mac_busy) begin
                    val_next   = mac_rnd;
                    state_next = sirc_pkg::ST_EMIT;
                end
            end
            sirc_pkg::ST_EMIT: begin
                if (emit_go) begin
                    mvalid_next  = 1'b1;
                    mdata_next   = sirc_pkg::sat16(scaled);
                    mlast_next   = (count_reg == 4'(sirc_pkg::MAX_OUT - 1))
                                   || (phase_adv[22:16] != target);
                    phase_next   = phase_adv;
                    out_ptr_next = out_ptr_reg + 7'd1;
                    count_next   = count_reg + 4'd1;
                    state_next   = sirc_pkg::ST_CHECK;
                end
            end
            default: begin
                state_next = sirc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sirc_pkg::ST_CLEAR;
            in_ptr_reg  <= '0;
            out_ptr_reg <= '0;
            phase_reg   <= '0;
            count_reg   <= '0;
            ratio_reg   <= sirc_pkg::UNITY_STEP;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_ptr_reg  <= in_ptr_next;
            out_ptr_reg <= out_ptr_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            mvalid_reg  <= mvalid_next;
            if (cfg_valid && cfg_ready) begin
                ratio_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        y_reg     <= y_next;
        val_reg   <= val_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        if (s_audio) begin
            sample_reg <= $signed(s_tdata[15:0]);
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

`ifndef SYNTHESIS
    // never more results per request than the limit
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 4'(sirc_pkg::MAX_OUT))
        else $error("result count above limit");

    // ring writes of MAC results happen only after the pipeline drained
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sirc_pkg::ST_SRC_WR || state_reg == sirc_pkg::ST_OUT_WR)
        |-> !mac_busy)
        else $error("ring written while MAC busy");

    // the eighth result of a request is marked last
    a_last_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sirc_pkg::ST_EMIT && emit_go
         && count_reg == 4'(sirc_pkg::MAX_OUT - 1)) |=> m_tlast && m_tvalid)
        else $error("final result not marked last");
`endif

endmodule
